// ===== rtl/ssps_pkg.sv =====
// Shared constants, types and a helper function for the square spiral peak search block.
package ssps_pkg;

  localparam int POSITION_BITS  = 24;
  localparam int READING_BITS   = 16;
  localparam int STEP_BITS      = 16;
  localparam int LIMIT_BITS     = 12;
  localparam int LINE_BITS      = 13;
  localparam int AXIS_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd2;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_RES   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD  = 2'd2;

  localparam logic [STEP_BITS-1:0]    STEP_RES_RESET   = 16'd1;
  localparam logic [LIMIT_BITS-1:0]   LINE_LIMIT_RESET = 12'd8;
  localparam logic [READING_BITS-1:0] THRESHOLD_RESET  = READING_BITS'(10000);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [READING_BITS-1:0]  reading_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  step_resolution;
    logic [LIMIT_BITS-1:0] line_limit;
    reading_t              found_threshold;
  } cfg_t;

  typedef struct packed {
    logic     req_type;
    pos_t     pos_x;
    pos_t     pos_y;
    reading_t power_reading;
  } req_t;

  typedef struct packed {
    logic [AXIS_BITS-1:0] move_axis;
    pos_t                 move_target;
    logic                 scan_found;
    logic                 scan_done;
    pos_t                 best_x;
    pos_t                 best_y;
    reading_t             best_reading;
  } move_t;

  typedef struct packed {
    logic [1:0] count;
    move_t      first;
    move_t      second;
  } step_out_t;

  // Target one step away from pos, wrapping modulo the position width.
  function automatic pos_t step_target(input pos_t pos, input logic [STEP_BITS-1:0] res,
                                       input logic dir);
    pos_t res_p;
    res_p = POSITION_BITS'(res);
    if (dir) begin
      step_target = pos - res_p;
    end else begin
      step_target = pos + res_p;
    end
  endfunction

endpackage

// ===== rtl/ssps_channels.sv =====
// Handshake channel interfaces for requests, moves and configuration writes.
interface ssps_req_if import ssps_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     req_type;
  pos_t     pos_x;
  pos_t     pos_y;
  reading_t power_reading;
  modport source (output valid, req_type, pos_x, pos_y, power_reading, input ready);
  modport sink (input valid, req_type, pos_x, pos_y, power_reading, output ready);
endinterface

interface ssps_move_if import ssps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AXIS_BITS-1:0] move_axis;
  pos_t                 move_target;
  logic                 scan_found;
  logic                 scan_done;
  pos_t                 best_x;
  pos_t                 best_y;
  reading_t             best_reading;
  modport source (output valid, move_axis, move_target, scan_found, scan_done, best_x, best_y,
                  best_reading, input ready);
  modport sink (input valid, move_axis, move_target, scan_found, scan_done, best_x, best_y,
                best_reading, output ready);
endinterface

interface ssps_cfg_if import ssps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ssps_cfg_regs.sv =====
// Configuration register file for step resolution, line limit and found threshold.
module ssps_cfg_regs import ssps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_resolution <= STEP_RES_RESET;
      cfg.line_limit      <= LINE_LIMIT_RESET;
      cfg.found_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_STEP_RES:   cfg.step_resolution <= STEP_BITS'(wr_data);
        CFG_LINE_LIMIT: cfg.line_limit      <= LIMIT_BITS'(wr_data);
        CFG_THRESHOLD:  cfg.found_threshold <= READING_BITS'(wr_data);
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/ssps_core.sv =====
// Spiral sequencer state and the combinational step logic for one registered item.
module ssps_core import ssps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      item_valid,
  input  req_t      item,
  output step_out_t step_out
);

  logic                  scanning;
  logic [AXIS_BITS-1:0]  current_axis;
  logic                  line_direction;
  logic [LINE_BITS-1:0]  line_length;
  logic [LINE_BITS-1:0]  points_in_line;
  pos_t                  peak_x;
  pos_t                  peak_y;
  reading_t              peak_reading;

  logic                  scanning_next;
  logic [AXIS_BITS-1:0]  current_axis_next;
  logic                  line_direction_next;
  logic [LINE_BITS-1:0]  line_length_next;
  logic [LINE_BITS-1:0]  points_in_line_next;
  pos_t                  peak_x_next;
  pos_t                  peak_y_next;
  reading_t              peak_reading_next;

  logic                  better;
  logic                  found;
  logic [LINE_BITS-1:0]  points_inc;
  logic                  line_end;
  logic                  limit_hit;
  pos_t                  move_pos;
  move_t                 first;
  move_t                 second;

  always_comb begin
    scanning_next       = scanning;
    current_axis_next   = current_axis;
    line_direction_next = line_direction;
    line_length_next    = line_length;
    points_in_line_next = points_in_line;
    peak_x_next         = peak_x;
    peak_y_next         = peak_y;
    peak_reading_next   = peak_reading;

    better     = item.power_reading > peak_reading;
    found      = item.power_reading > cfg.found_threshold;
    points_inc = points_in_line + LINE_BITS'(1);
    line_end   = points_inc > line_length;
    limit_hit  = line_length > LINE_BITS'(cfg.line_limit);
    move_pos   = item.pos_x;

    step_out.count = 2'd0;
    first  = '0;
    second = '0;

    if (item_valid) begin
      if (item.req_type == REQ_START) begin
        scanning_next       = 1'b1;
        current_axis_next   = AXIS_X;
        line_direction_next = 1'b0;
        line_length_next    = LINE_BITS'(1);
        points_in_line_next = '0;
        peak_x_next         = item.pos_x;
        peak_y_next         = item.pos_y;
        peak_reading_next   = item.power_reading;
        step_out.count      = 2'd1;
        first.move_axis     = AXIS_X;
        first.move_target   = step_target(item.pos_x, cfg.step_resolution, 1'b0);
      end else if (scanning) begin
        if (better) begin
          peak_x_next       = item.pos_x;
          peak_y_next       = item.pos_y;
          peak_reading_next = item.power_reading;
        end
        if (found || (line_end && limit_hit)) begin
          scanning_next      = 1'b0;
          step_out.count     = 2'd2;
          first.move_axis    = AXIS_X;
          first.move_target  = peak_x_next;
          first.scan_found   = found;
          second.move_axis   = AXIS_Y;
          second.move_target = peak_y_next;
          second.scan_found  = found;
          second.scan_done   = 1'b1;
        end else begin
          points_in_line_next = points_inc;
          if (line_end) begin
            points_in_line_next = '0;
            if (current_axis == AXIS_X) begin
              current_axis_next   = AXIS_Y;
              line_length_next    = line_length + LINE_BITS'(1);
              line_direction_next = ~line_direction;
            end else begin
              current_axis_next = AXIS_X;
            end
          end
          if (current_axis_next == AXIS_X) begin
            move_pos = item.pos_x;
          end else begin
            move_pos = item.pos_y;
          end
          step_out.count    = 2'd1;
          first.move_axis   = current_axis_next;
          first.move_target = step_target(move_pos, cfg.step_resolution, line_direction_next);
        end
      end
    end

    first.best_x        = peak_x_next;
    first.best_y        = peak_y_next;
    first.best_reading  = peak_reading_next;
    second.best_x       = peak_x_next;
    second.best_y       = peak_y_next;
    second.best_reading = peak_reading_next;
    step_out.first      = first;
    step_out.second     = second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning       <= 1'b0;
      current_axis   <= AXIS_X;
      line_direction <= 1'b0;
      line_length    <= LINE_BITS'(1);
      points_in_line <= '0;
      peak_x         <= '0;
      peak_y         <= '0;
      peak_reading   <= '0;
    end else begin
      scanning       <= scanning_next;
      current_axis   <= current_axis_next;
      line_direction <= line_direction_next;
      line_length    <= line_length_next;
      points_in_line <= points_in_line_next;
      peak_x         <= peak_x_next;
      peak_y         <= peak_y_next;
      peak_reading   <= peak_reading_next;
    end
  end

endmodule

// ===== rtl/ssps_out_queue.sv =====
// Small result queue that takes up to two moves per cycle and hands out one per cycle while the consumer is ready.
module ssps_out_queue import ssps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_out_t push,
  input  logic      pop,
  output logic      out_valid,
  output move_t     out_data,
  output logic      room_for_next
);

  move_t                     entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] head;
  logic [QUEUE_PTR_BITS-1:0] tail;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic [QUEUE_CNT_BITS-1:0] count_next;
  logic                      do_pop;
  logic [QUEUE_PTR_BITS-1:0] tail_plus_one;

  assign out_valid     = count != '0;
  assign out_data      = entries[head];
  assign do_pop        = pop && out_valid;
  assign tail_plus_one = tail + QUEUE_PTR_BITS'(1);
  assign count_next    = count + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(do_pop);

  // A new item may enter if the queue can still take two more results next cycle.
  assign room_for_next = count_next <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[tail_plus_one] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QUEUE_PTR_BITS'(do_pop);
      tail  <= tail + QUEUE_PTR_BITS'(push.count);
      count <= count_next;
    end
  end

endmodule

// ===== rtl/square_spiral_peak_search.sv =====
// Top level of the square spiral peak search sequencer.
//
//   Channel  Direction  Payload
//   req      in         req_type, pos_x, pos_y, power_reading
//   move     out        move_axis, move_target, scan_found, scan_done, best_x, best_y,
//                       best_reading
//   cfg      in         index, data (step_resolution, line_limit, found_threshold)
//
// An accepted item is registered, then processed in the next cycle by the step logic,
// which writes zero, one or two moves into a four-entry result queue.
// A move becomes valid once its item has passed the stage register and been written into the
// result queue; one item per cycle is sustained while the result queue has room.
// The request side stalls only when the result queue could not absorb two more moves.
// Reset is synchronous and returns the registers and scan state to their defaults.
module square_spiral_peak_search import ssps_pkg::*; (
  input logic         clk,
  input logic         rst,
  ssps_req_if.sink    req,
  ssps_move_if.source move,
  ssps_cfg_if.sink    cfg
);

  cfg_t      cfg_regs;
  logic      stage_valid;
  req_t      stage_item;
  step_out_t step_out;
  move_t     head_move;
  logic      room_for_next;
  logic      req_fire;

  assign cfg.ready = 1'b1;
  assign req.ready = room_for_next;
  assign req_fire  = req.valid && req.ready;

  ssps_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= req_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      stage_item.req_type      <= req.req_type;
      stage_item.pos_x         <= req.pos_x;
      stage_item.pos_y         <= req.pos_y;
      stage_item.power_reading <= req.power_reading;
    end
  end

  ssps_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_regs),
    .item_valid (stage_valid),
    .item       (stage_item),
    .step_out   (step_out)
  );

  ssps_out_queue u_out_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (step_out),
    .pop           (move.ready),
    .out_valid     (move.valid),
    .out_data      (head_move),
    .room_for_next (room_for_next)
  );

  assign move.move_axis    = head_move.move_axis;
  assign move.move_target  = head_move.move_target;
  assign move.scan_found   = head_move.scan_found;
  assign move.scan_done    = head_move.scan_done;
  assign move.best_x       = head_move.best_x;
  assign move.best_y       = head_move.best_y;
  assign move.best_reading = head_move.best_reading;

endmodule
